FILE: hdl/qdr_pkg.sv
// Package for the quadrature decoder with speed measurement.
// Holds the channel structs, the queue entry, the back-end state type and shared constants.
// Has no dependencies.
package qdr_pkg;

  // Width of the running position count.
  localparam int CountWidth = 32;
  localparam int TimeWidth  = 32;
  localparam int CprWidth   = 16;
  localparam int OutWidth   = 32;

  // Reset value of counts per revolution.
  localparam logic [CprWidth-1:0] CprReset = 16'd1024;

  // Action codes of an input item.
  localparam logic [1:0] ActSample = 2'd0;
  localparam logic [1:0] ActTick   = 2'd1;
  localparam logic [1:0] ActRpm    = 2'd2;

  // Transition code {previous A, previous B, new A, new B}: one bit per code.
  localparam logic [15:0] QuadUpMask   = 16'h2814;
  localparam logic [15:0] QuadDownMask = 16'h4182;

  // 60e6 us/min times 256 (Q24.8) is 234375 * 2^16.
  localparam int                 RpmMulWidth = 18;
  localparam logic [RpmMulWidth-1:0] RpmMul  = 18'd234375;
  localparam int                 RpmShift    = 16;

  // Divider geometry.
  localparam int NumWidth = CountWidth + RpmMulWidth + RpmShift;
  localparam int DenWidth = TimeWidth + CprWidth;
  localparam int StepCntWidth = $clog2(NumWidth);

  // Queue between front and back.
  localparam int QueueDepth    = 4;
  localparam int QueuePtrWidth = $clog2(QueueDepth);

  // Saturation limits of the Q24.8 result.
  localparam logic [OutWidth-1:0] RpmMaxPos = 32'h7FFF_FFFF;
  localparam logic [OutWidth-1:0] RpmMaxNeg = 32'h8000_0000;

  typedef struct packed {
    logic [1:0] action;
    logic       pin_a;
    logic       pin_b;
  } in_item_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] position_count;
    logic signed [OutWidth-1:0] rpm_fixed;
    logic                       rpm_valid;
    logic                       divide_by_zero;
  } out_item_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic                  is_rpm;
    logic [OutWidth-1:0]   pos;
    logic [CountWidth-1:0] diff;
    logic [TimeWidth-1:0]  dt;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } back_state_e;

  // Low output bits of the count, sign extended first.
  function automatic logic [OutWidth-1:0] pos_of(input logic [CountWidth-1:0] c);
    logic signed [63:0] w;
    w = 64'(signed'(c));
    return w[OutWidth-1:0];
  endfunction

endpackage

FILE: hdl/qdr_front.sv
// Front end of the quadrature decoder: accepts items, keeps count, timer and references.
// Pushes one classified job per item into the queue. Depends on qdr_pkg.
module qdr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qdr_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output qdr_pkg::job_t     job_o
);

  logic [1:0]                    last_q, last_d;
  logic [qdr_pkg::CountWidth-1:0] count_q, count_d;
  logic [qdr_pkg::TimeWidth-1:0]  time_q, time_d;
  logic [qdr_pkg::TimeWidth-1:0]  ref_time_q, ref_time_d;
  logic [qdr_pkg::CountWidth-1:0] ref_count_q, ref_count_d;
  logic [3:0]                    code;
  logic                          accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign code       = {last_q, in_data_i.pin_a, in_data_i.pin_b};

  always_comb begin
    last_d      = last_q;
    count_d     = count_q;
    time_d      = time_q;
    ref_time_d  = ref_time_q;
    ref_count_d = ref_count_q;
    job_o.is_rpm = 1'b0;
    job_o.diff   = count_q - ref_count_q;
    job_o.dt     = time_q - ref_time_q;
    unique case (in_data_i.action)
      qdr_pkg::ActSample: begin
        if (qdr_pkg::QuadUpMask[code]) begin
          count_d = count_q + 1'b1;
        end else if (qdr_pkg::QuadDownMask[code]) begin
          count_d = count_q - 1'b1;
        end
        last_d = {in_data_i.pin_a, in_data_i.pin_b};
      end
      qdr_pkg::ActTick: begin
        time_d = time_q + 1'b1;
      end
      qdr_pkg::ActRpm: begin
        job_o.is_rpm = 1'b1;
        ref_time_d   = time_q;
        ref_count_d  = count_q;
      end
      default: begin
      end
    endcase
    job_o.pos = qdr_pkg::pos_of(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      count_q     <= '0;
      time_q      <= '0;
      ref_time_q  <= '0;
      ref_count_q <= '0;
    end else if (accept) begin
      last_q      <= last_d;
      count_q     <= count_d;
      time_q      <= time_d;
      ref_time_q  <= ref_time_d;
      ref_count_q <= ref_count_d;
    end
  end

endmodule

FILE: hdl/qdr_queue.sv
// Short job queue between the front and back ends of the quadrature decoder.
// Register-based FIFO of qdr_pkg::job_t entries. Depends on qdr_pkg.
module qdr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qdr_pkg::job_t job_i,
  input  logic          pop_i,
  output qdr_pkg::job_t head_o,
  output logic          full_o,
  output logic          empty_o
);

  qdr_pkg::job_t                    mem_q [qdr_pkg::QueueDepth];
  logic [qdr_pkg::QueuePtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [qdr_pkg::QueuePtrWidth:0]   fill_q;

  assign full_o  = (fill_q == (qdr_pkg::QueuePtrWidth+1)'(qdr_pkg::QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/qdr_back.sv
// Back end of the quadrature decoder: turns queued jobs into results.
// Speed jobs run a multiply and a restoring divider; holds the output register. Uses qdr_pkg.
module qdr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [qdr_pkg::CprWidth-1:0]  cpr_i,
  input  qdr_pkg::job_t                 head_i,
  input  logic                          q_empty_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output qdr_pkg::out_item_t            out_data_o
);

  qdr_pkg::back_state_e state_q, state_d;

  logic                               neg_q;
  logic [qdr_pkg::CountWidth-1:0]     mag_q;
  logic [qdr_pkg::TimeWidth-1:0]      dt_q;
  logic [qdr_pkg::OutWidth-1:0]       pos_q;
  logic [qdr_pkg::NumWidth-1:0]       num_q;
  logic [qdr_pkg::DenWidth-1:0]       den_q;
  logic [qdr_pkg::DenWidth:0]         rem_q;
  logic [qdr_pkg::StepCntWidth-1:0]   step_q;
  logic                               out_valid_q;
  qdr_pkg::out_item_t                 out_q;

  logic                               out_free;
  logic                               take;
  logic                               load_plain;
  logic                               load_rpm;
  logic                               last_step;
  logic [qdr_pkg::DenWidth:0]         rem_sh;
  logic                               fits;
  logic                               hi_nz;
  logic [qdr_pkg::OutWidth-1:0]       rpm_val;
  logic                               dz;
  logic [qdr_pkg::CountWidth+qdr_pkg::RpmMulWidth-1:0] prod;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_step = (step_q == qdr_pkg::StepCntWidth'(qdr_pkg::NumWidth - 1));
  assign rem_sh    = {rem_q[qdr_pkg::DenWidth-1:0], num_q[qdr_pkg::NumWidth-1]};
  assign fits      = (rem_sh >= {1'b0, den_q});
  assign prod      = mag_q * qdr_pkg::RpmMul;
  assign dz        = (den_q == '0);
  assign hi_nz     = |num_q[qdr_pkg::NumWidth-1:qdr_pkg::OutWidth];

  // Saturate the finished quotient into signed Q24.8.
  always_comb begin
    if (dz) begin
      rpm_val = '0;
    end else if (neg_q) begin
      if (hi_nz || (num_q[qdr_pkg::OutWidth-1] && |num_q[qdr_pkg::OutWidth-2:0])) begin
        rpm_val = qdr_pkg::RpmMaxNeg;
      end else begin
        rpm_val = -num_q[qdr_pkg::OutWidth-1:0];
      end
    end else if (hi_nz || num_q[qdr_pkg::OutWidth-1]) begin
      rpm_val = qdr_pkg::RpmMaxPos;
    end else begin
      rpm_val = num_q[qdr_pkg::OutWidth-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qdr_pkg::BK_IDLE: begin
        if (!q_empty_i && head_i.is_rpm) begin
          state_d = qdr_pkg::BK_MUL;
        end
      end
      qdr_pkg::BK_MUL: state_d = qdr_pkg::BK_DIV;
      qdr_pkg::BK_DIV: begin
        if (last_step) begin
          state_d = qdr_pkg::BK_OUT;
        end
      end
      qdr_pkg::BK_OUT: begin
        if (out_free) begin
          state_d = qdr_pkg::BK_IDLE;
        end
      end
      default: state_d = qdr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    take       = 1'b0;
    load_plain = 1'b0;
    load_rpm   = 1'b0;
    unique case (state_q)
      qdr_pkg::BK_IDLE: begin
        take       = !q_empty_i && (head_i.is_rpm || out_free);
        load_plain = !q_empty_i && !head_i.is_rpm && out_free;
      end
      qdr_pkg::BK_OUT: load_rpm = out_free;
      default: begin
      end
    endcase
  end

  assign pop_o       = take;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qdr_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_plain || load_rpm) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == qdr_pkg::BK_MUL) begin
        step_q <= '0;
      end else if (state_q == qdr_pkg::BK_DIV) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && head_i.is_rpm) begin
      neg_q <= head_i.diff[qdr_pkg::CountWidth-1];
      mag_q <= head_i.diff[qdr_pkg::CountWidth-1] ? -head_i.diff : head_i.diff;
      dt_q  <= head_i.dt;
      pos_q <= head_i.pos;
    end
    if (state_q == qdr_pkg::BK_MUL) begin
      num_q <= {prod, {qdr_pkg::RpmShift{1'b0}}};
      den_q <= dt_q * cpr_i;
      rem_q <= '0;
    end else if (state_q == qdr_pkg::BK_DIV) begin
      num_q <= {num_q[qdr_pkg::NumWidth-2:0], fits};
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
    if (load_plain) begin
      out_q.position_count <= head_i.pos;
      out_q.rpm_fixed      <= '0;
      out_q.rpm_valid      <= 1'b0;
      out_q.divide_by_zero <= 1'b0;
    end else if (load_rpm) begin
      out_q.position_count <= pos_q;
      out_q.rpm_fixed      <= rpm_val;
      out_q.rpm_valid      <= 1'b1;
      out_q.divide_by_zero <= dz;
    end
  end

endmodule

FILE: hdl/quadrature_decoder_with_rpm_top.sv
// Top level of the x4 quadrature decoder with speed measurement.
// Instantiates qdr_front, qdr_queue and qdr_back and holds the configuration register.
// Depends on qdr_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one request per item: a pin
//   sample, a microsecond tick or a speed request. Every request yields exactly one result on
//   the output channel (out_valid_o / out_ready_i / out_data_o), in request order.
//   The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes counts per
//   revolution; it is always ready and should only be written while the block is idle.
// Path and throughput:
//   A sample, tick or unused request passes through the queue and is then loaded into the
//   output register; such requests stream at one per cycle while out_ready_i stays high and
//   no speed request is in the back. A speed request leaves the queue, then goes through the
//   32x18 scale multiply and the 32x16 divisor multiply, then the restoring divider at one
//   quotient bit per cycle over the 66-bit numerator, then the output load. The four-entry
//   queue lets the front keep accepting samples and ticks while that runs.
// Reset:
//   The asynchronous active-low reset clears count, timer, references, the queue pointers and
//   the output valid flag, and loads counts per revolution with 1024.
// Stalls:
//   When the receiver holds out_ready_i low, the result stays in the output register, the
//   queue fills, and in_ready_o drops once the queue is full; nothing is lost.
module quadrature_decoder_with_rpm_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  qdr_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output qdr_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qdr_pkg::CprWidth-1:0] cfg_data_i
);

  logic [qdr_pkg::CprWidth-1:0] cpr_q;
  logic                         push;
  logic                         pop;
  logic                         q_full;
  logic                         q_empty;
  qdr_pkg::job_t                job_in;
  qdr_pkg::job_t                job_head;

  // Counts per revolution. Writes are taken on any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= qdr_pkg::CprReset;
    end else if (cfg_valid_i) begin
      cpr_q <= cfg_data_i;
    end
  end

  // The front decodes phases, runs the timer and snapshots the speed references.
  qdr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // The queue decouples the front from the back, which is busy while it computes a speed.
  qdr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .head_o  (job_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back computes speed results and drives the output register.
  qdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cpr_i       (cpr_q),
    .head_i      (job_head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the x4 quadrature decoder with speed measurement.
// Drives pin samples, microsecond ticks and speed requests, predicts every result and checks it.
// Depends on qdr_pkg and quadrature_decoder_with_rpm_top.
module tb;
  import qdr_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 8;
  localparam int PhaseItems    = 200;
  localparam int TimeoutCycles = 600000;
  // This covers a speed request still in flight and any late or stray result.
  localparam int SettleCycles  = 100;

  // The fourth action code does nothing but report the count.
  localparam logic [1:0] ActUnused = 2'd3;

  // Transition code {old A, old B, new A, new B}: one bit per code that moves the count.
  localparam logic [15:0] StepUpSet   = (16'd1 << 4'b1101) | (16'd1 << 4'b0100) |
                                        (16'd1 << 4'b0010) | (16'd1 << 4'b1011);
  localparam logic [15:0] StepDownSet = (16'd1 << 4'b1110) | (16'd1 << 4'b0111) |
                                        (16'd1 << 4'b0001) | (16'd1 << 4'b1000);

  // 60e6 microseconds per minute times 256 for the Q24.8 result.
  localparam logic [63:0] UsPerMinQ8 = 64'd15360000000;

  logic                clk;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CprWidth-1:0] cfg_data_i;

  quadrature_decoder_with_rpm_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // One row of the directed table. Where typed is set, want holds the result read off by hand.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  // Mirror of the decoder state, at its reset values.
  logic [1:0]          phase_prev = '0;
  logic [31:0]         pos_cnt    = '0;
  logic [31:0]         usec_now   = '0;
  logic [31:0]         mark_usec  = '0;
  logic [31:0]         mark_pos   = '0;
  logic [CprWidth-1:0] rev_counts = 16'd1024;

  // Results still owed by the block, oldest first.
  out_item_t pending_results[$];
  int        fails = 0;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Advances the mirrored state by one request and returns the result it must produce.
  function automatic out_item_t decode_step(in_item_t it);
    out_item_t   res;
    logic [3:0]  code;
    logic [31:0] diff;
    logic [31:0] mag;
    logic [31:0] dt;
    logic [47:0] den;
    logic [95:0] quo;
    logic        neg;
    res = '0;
    case (it.action)
      ActSample: begin
        code = {phase_prev, it.pin_a, it.pin_b};
        if (StepUpSet[code]) begin
          pos_cnt = pos_cnt + 32'd1;
        end else if (StepDownSet[code]) begin
          pos_cnt = pos_cnt - 32'd1;
        end
        phase_prev = {it.pin_a, it.pin_b};
      end
      ActTick: begin
        usec_now = usec_now + 32'd1;
      end
      ActRpm: begin
        // Count difference is read as signed, elapsed time as unsigned, both modulo 2^32.
        diff = pos_cnt - mark_pos;
        neg  = diff[31];
        mag  = neg ? (32'd0 - diff) : diff;
        dt   = usec_now - mark_usec;
        den  = {16'd0, dt} * {32'd0, rev_counts};
        res.rpm_valid = 1'b1;
        if (den == '0) begin
          res.divide_by_zero = 1'b1;
        end else begin
          // The quotient truncates toward zero, then saturates to the signed 32-bit range.
          quo = ({64'd0, mag} * {32'd0, UsPerMinQ8}) / {48'd0, den};
          if (neg) begin
            res.rpm_fixed = (quo > 96'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
          end else begin
            res.rpm_fixed = (quo > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
          end
        end
        mark_usec = usec_now;
        mark_pos  = pos_cnt;
      end
      default: begin
      end
    endcase
    res.position_count = pos_cnt;
    return res;
  endfunction

  function automatic stim_row_t row(logic [1:0] act, logic a, logic b, bit typed = 1'b0,
                                    int pos = 0, int rpm = 0, bit vld = 1'b0, bit dz = 1'b0);
    stim_row_t r;
    r.item.action             = act;
    r.item.pin_a              = a;
    r.item.pin_b              = b;
    r.typed                   = typed;
    r.want.position_count     = pos;
    r.want.rpm_fixed          = rpm;
    r.want.rpm_valid          = vld;
    r.want.divide_by_zero     = dz;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      fails++;
    end
  endtask

  // Entered and left at a falling edge. A zero gap keeps valid high straight into the next
  // request, so valid is never dropped and raised in the same step.
  task automatic send_item(in_item_t it, bit typed, out_item_t want, int gap);
    out_item_t predicted;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    forever begin
      @(posedge clk);
      if (in_ready_o) break;
    end
    predicted = decode_step(it);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Holds the sender back until every owed result has been taken.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Receiver: stalls a random number of cycles before each result, with quiet stretches.
  initial begin
    int        stall;
    int        taken;
    int        mode;
    out_item_t want;
    out_ready_i = 1'b0;
    taken = 0;
    mode  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (taken % 40 == 0) mode = $urandom_range(0, 2);
      stall = (mode == 0) ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready_i = 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid_o) break;
      end
      taken++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: position_count 0x%08h",
               out_data_o.position_count);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("position_count", want.position_count, out_data_o.position_count);
        check_field("rpm_fixed", want.rpm_fixed, out_data_o.rpm_fixed);
        check_field("rpm_valid", 32'(want.rpm_valid), 32'(out_data_o.rpm_valid));
        check_field("divide_by_zero", 32'(want.divide_by_zero),
                    32'(out_data_o.divide_by_zero));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    stim_row_t           directed[$];
    logic [CprWidth-1:0] cpr_plan[$];
    in_item_t            it;
    out_item_t           none;
    logic [1:0]          walk_ab;
    int                  dir;
    int                  gap_mode;
    int                  pick;

    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    none        = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Right after reset: a speed request with no elapsed time, the unused action, a tick
    // with its pins ignored, one full turn down and up, then both double steps.
    directed.push_back(row(ActRpm,    1'b0, 1'b0, 1'b1,  0, 0, 1'b1, 1'b1));
    directed.push_back(row(ActUnused, 1'b1, 1'b1, 1'b1,  0, 0, 1'b0, 1'b0));
    directed.push_back(row(ActTick,   1'b1, 1'b1, 1'b1,  0, 0, 1'b0, 1'b0));
    directed.push_back(row(ActSample, 1'b0, 1'b1, 1'b1, -1));
    directed.push_back(row(ActSample, 1'b1, 1'b1, 1'b1, -2));
    directed.push_back(row(ActSample, 1'b1, 1'b0, 1'b1, -3));
    directed.push_back(row(ActSample, 1'b0, 1'b0, 1'b1, -4));
    directed.push_back(row(ActSample, 1'b1, 1'b0, 1'b1, -3));
    directed.push_back(row(ActSample, 1'b1, 1'b1, 1'b1, -2));
    directed.push_back(row(ActSample, 1'b0, 1'b1, 1'b1, -1));
    directed.push_back(row(ActSample, 1'b0, 1'b0, 1'b1,  0));
    directed.push_back(row(ActSample, 1'b1, 1'b1, 1'b1,  0));
    directed.push_back(row(ActSample, 1'b0, 1'b0, 1'b1,  0));
    // A step down, a double step, a few ticks, then a negative speed.
    directed.push_back(row(ActSample, 1'b0, 1'b1));
    directed.push_back(row(ActSample, 1'b1, 1'b0));
    directed.push_back(row(ActTick,   1'b0, 1'b0));
    directed.push_back(row(ActTick,   1'b1, 1'b0));
    directed.push_back(row(ActRpm,    1'b0, 1'b1));
    // A second request in the same microsecond has no elapsed time.
    directed.push_back(row(ActRpm,    1'b1, 1'b0, 1'b1, -1, 0, 1'b1, 1'b1));
    directed.push_back(row(ActSample, 1'b0, 1'b0));
    directed.push_back(row(ActSample, 1'b1, 1'b0));
    directed.push_back(row(ActTick,   1'b0, 1'b1));
    directed.push_back(row(ActRpm,    1'b1, 1'b1));
    directed.push_back(row(ActUnused, 1'b0, 1'b0));

    foreach (directed[i]) begin
      send_item(directed[i].item, directed[i].typed, directed[i].want, $urandom_range(0, 3));
    end

    // Settings: the smallest divisor scale saturates readily, the largest gives tiny speeds.
    cpr_plan.push_back(16'd1);
    cpr_plan.push_back(16'd65535);
    cpr_plan.push_back(16'd2);
    cpr_plan.push_back(16'($urandom_range(3, 65534)));
    cpr_plan.push_back(16'd1);
    cpr_plan.push_back(16'($urandom_range(3, 65534)));

    walk_ab  = phase_prev;
    dir      = 1;
    gap_mode = 0;
    foreach (cpr_plan[p]) begin
      // The register is only written with nothing in flight.
      drain_results();
      cfg_valid_i = 1'b1;
      cfg_data_i  = cpr_plan[p];
      forever begin
        @(posedge clk);
        if (cfg_ready_o) break;
      end
      rev_counts = cpr_plan[p];
      @(negedge clk);
      cfg_valid_i = 1'b0;
      @(negedge clk);

      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) gap_mode = $urandom_range(0, 2);
        // Once in the run the sender waits for the output side to empty mid-phase.
        if (p == 2 && n == PhaseItems / 2) drain_results();
        if ($urandom_range(0, 49) == 0) dir = -dir;
        pick = $urandom_range(0, 99);
        it.pin_a = 1'($urandom_range(0, 1));
        it.pin_b = 1'($urandom_range(0, 1));
        if (pick < 55) begin
          // Clean Gray-code step in the current direction, or a hold now and then.
          it.action = ActSample;
          if ($urandom_range(0, 9) != 0) begin
            case (walk_ab)
              2'b00:   walk_ab = (dir > 0) ? 2'b10 : 2'b01;
              2'b10:   walk_ab = (dir > 0) ? 2'b11 : 2'b00;
              2'b11:   walk_ab = (dir > 0) ? 2'b01 : 2'b10;
              default: walk_ab = (dir > 0) ? 2'b00 : 2'b11;
            endcase
          end
          {it.pin_a, it.pin_b} = walk_ab;
        end else if (pick < 62) begin
          // Noise on the pins, which brings in double steps.
          it.action = ActSample;
          walk_ab   = {it.pin_a, it.pin_b};
        end else if (pick < 92) begin
          it.action = ActTick;
        end else if (pick < 97) begin
          it.action = ActRpm;
        end else begin
          it.action = ActUnused;
        end
        send_item(it, 1'b0, none, (gap_mode == 0) ? 0 : $urandom_range(0, 10));
      end
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/qdr_pkg.sv
hdl/qdr_front.sv
hdl/qdr_queue.sv
hdl/qdr_back.sv
hdl/quadrature_decoder_with_rpm_top.sv
sim/tb.sv
